// ===== rtl/core/bchd_pkg.sv =====
package bchd_pkg;

    // Sizing
    localparam int NUM_BUTTONS = 8;
    localparam int TICK_WIDTH  = 16;
    localparam int MAX_SCAN    = 8;
    localparam int SCAN_LIMIT  = (NUM_BUTTONS < MAX_SCAN) ? NUM_BUTTONS : MAX_SCAN;
    localparam int IDX_W       = (SCAN_LIMIT > 1) ? $clog2(SCAN_LIMIT) : 1;

    // Field widths
    localparam int RAW_W    = 8;
    localparam int CNT_W    = 4;
    localparam int THR_W    = 16;
    localparam int CLICK_W  = 8;
    localparam int EVT_W    = 4;
    localparam int BIDX_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int CMP_W    = (TICK_WIDTH > THR_W) ? TICK_WIDTH : THR_W;

    // Output bus widths
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_USE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS    = 3'd5;

    // Configuration reset values
    localparam logic [RAW_W-1:0] RST_PRESSED_MASK = 8'd0;
    localparam logic [CNT_W-1:0] RST_IN_USE       = 4'd8;
    localparam logic [THR_W-1:0] RST_SHORT_TICKS  = 16'd3;
    localparam logic [THR_W-1:0] RST_LONG_TICKS   = 16'd50;
    localparam logic [THR_W-1:0] RST_HOLD_TICKS   = 16'd150;
    localparam logic [THR_W-1:0] RST_GAP_TICKS    = 16'd15;

    localparam logic [CLICK_W-1:0] CLICK_MAX = '1;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_DOWN  = 2'd1,
        MODE_MULTI = 2'd2
    } t_mode;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE        = 4'd0,
        EV_DOWN        = 4'd1,
        EV_CLICK       = 4'd2,
        EV_DOUBLE      = 4'd3,
        EV_REPEAT      = 4'd4,
        EV_SHORT_START = 4'd5,
        EV_SHORT_UP    = 4'd6,
        EV_LONG_START  = 4'd7,
        EV_LONG_UP     = 4'd8,
        EV_HOLD        = 4'd9,
        EV_HOLD_UP     = 4'd10
    } t_event;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // One entry of the per-button state memory
    typedef struct packed {
        t_mode                  mode;
        logic [TICK_WIDTH-1:0]  ticks;
        logic [CLICK_W-1:0]     clicks;
        t_event                 evt;
    } t_btn_state;

    // Map a pending click count to its report
    function automatic t_event click_event(input logic [CLICK_W-1:0] n);
        t_event ev;
        if (n <= CLICK_W'(1)) begin
            ev = EV_CLICK;
        end else if (n == CLICK_W'(2)) begin
            ev = EV_DOUBLE;
        end else begin
            ev = EV_REPEAT;
        end
        return ev;
    endfunction

endpackage

// ===== rtl/core/button_click_and_hold_detector_unit.sv =====
// Button click and hold detector. Each accepted input transaction is one scan tick carrying
// the raw pin levels of up to eight buttons; a button is pressed when its raw bit equals its
// bit in the pressed-level mask. Per-button state (mode, tick counter, click counter, last
// event) lives in a small synchronous state memory and is read, updated and written back one
// button per cycle while the output is not stalled, highest index first. Each tick yields
// one output transaction per scanned button (index in tuser, event, new-event flag and on
// the last one the active count in tdata), ending with button 0 flagged by tlast. A new
// tick is accepted only after the previous tick is fully written back, paced by the single
// memory read port. A tick with zero buttons in use gives no output. The user must write
// configuration through the cfg channel only while no tick is in flight (not enforced).
module button_click_and_hold_detector_unit
    import bchd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_data,

    // scan tick input
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [RAW_W-1:0]        s_axis_tdata,   // [7:0] raw_levels

    // per-button results
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,   // [3:0] event_code, [4] event_new,
                                                    // [8:5] active_count, [15:9] zero
    output logic [OUT_USER_W-1:0]   m_axis_tuser,   // [2:0] button_index, [7:3] zero
    output logic                    m_axis_tlast
);

    // Configuration registers
    logic [RAW_W-1:0]   r_pressed_mask;
    logic [CNT_W-1:0]   r_in_use;
    logic [THR_W-1:0]   r_short_ticks;
    logic [THR_W-1:0]   r_long_ticks;
    logic [THR_W-1:0]   r_hold_ticks;
    logic [THR_W-1:0]   r_gap_ticks;

    // Control
    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [RAW_W-1:0]   r_raw;
    logic [CNT_W-1:0]   r_active;
    logic [CNT_W-1:0]   n_active;

    // State memory
    t_btn_state         r_mem [SCAN_LIMIT];
    logic [SCAN_LIMIT-1:0] r_mem_vld;
    t_btn_state         r_rdata;
    logic               r_rdata_vld;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;

    // Output register
    logic               r_out_valid;
    logic [BIDX_W-1:0]  r_out_index;
    t_event             r_out_event;
    logic               r_out_new;
    logic [CNT_W-1:0]   r_out_active;
    logic               r_out_last;

    // Datapath
    logic [CNT_W-1:0]   eff_count;
    logic               in_accept;
    logic               out_free;
    logic               pressed;
    logic               is_last;
    t_btn_state         cur;
    t_btn_state         nxt;
    logic               raised;
    logic               now_active;
    logic [TICK_WIDTH:0]   tick_inc;
    logic [CMP_W-1:0]      t_cmp;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_mask <= RST_PRESSED_MASK;
            r_in_use       <= RST_IN_USE;
            r_short_ticks  <= RST_SHORT_TICKS;
            r_long_ticks   <= RST_LONG_TICKS;
            r_hold_ticks   <= RST_HOLD_TICKS;
            r_gap_ticks    <= RST_GAP_TICKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRESSED_MASK: r_pressed_mask <= i_cfg_data[RAW_W-1:0];
                CFG_IN_USE:       r_in_use       <= i_cfg_data[CNT_W-1:0];
                CFG_SHORT_TICKS:  r_short_ticks  <= i_cfg_data[THR_W-1:0];
                CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_data[THR_W-1:0];
                CFG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_data[THR_W-1:0];
                CFG_GAP_TICKS:    r_gap_ticks    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the scan count to what the memory holds
    assign eff_count = (r_in_use > CNT_W'(SCAN_LIMIT)) ? CNT_W'(SCAN_LIMIT) : r_in_use;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Button update for the entry just read
    always_comb begin
        cur      = r_rdata_vld ? r_rdata : '0;
        nxt      = cur;
        raised   = 1'b0;
        pressed  = ~(r_raw[r_idx] ^ r_pressed_mask[r_idx]);
        tick_inc = {1'b0, cur.ticks} + (TICK_WIDTH+1)'(1);

        // advance the tick counter while pressed or waiting for clicks, reloading it from the hold threshold at the top
        if (cur.mode == MODE_DOWN || cur.mode == MODE_MULTI) begin
            if (tick_inc >= {1'b0, {TICK_WIDTH{1'b1}}}) begin
                nxt.ticks = TICK_WIDTH'(r_hold_ticks);
            end else begin
                nxt.ticks = tick_inc[TICK_WIDTH-1:0];
            end
        end
        t_cmp = CMP_W'(nxt.ticks);

        unique case (cur.mode)
            MODE_DOWN: begin
                if (pressed) begin
                    if (cur.clicks != '0) begin
                        if (t_cmp > CMP_W'(r_gap_ticks)) begin
                            nxt.evt    = click_event(cur.clicks);
                            raised     = 1'b1;
                            nxt.ticks  = '0;
                            nxt.clicks = '0;
                        end
                    end else if (t_cmp >= CMP_W'(r_hold_ticks)) begin
                        if (cur.evt != EV_HOLD) begin
                            nxt.evt = EV_HOLD;
                            raised  = 1'b1;
                        end
                    end else if (t_cmp >= CMP_W'(r_long_ticks)) begin
                        if (cur.evt != EV_LONG_START) begin
                            nxt.evt = EV_LONG_START;
                            raised  = 1'b1;
                        end
                    end else if (t_cmp >= CMP_W'(r_short_ticks)) begin
                        if (cur.evt != EV_SHORT_START) begin
                            nxt.evt = EV_SHORT_START;
                            raised  = 1'b1;
                        end
                    end
                end else begin
                    if (t_cmp >= CMP_W'(r_hold_ticks)) begin
                        nxt.evt  = EV_HOLD_UP;
                        raised   = 1'b1;
                        nxt.mode = MODE_IDLE;
                    end else if (t_cmp >= CMP_W'(r_long_ticks)) begin
                        nxt.evt  = EV_LONG_UP;
                        raised   = 1'b1;
                        nxt.mode = MODE_IDLE;
                    end else if (t_cmp >= CMP_W'(r_short_ticks)) begin
                        nxt.evt  = EV_SHORT_UP;
                        raised   = 1'b1;
                        nxt.mode = MODE_IDLE;
                    end else begin
                        nxt.mode = MODE_MULTI;
                        if (cur.clicks != CLICK_MAX) begin
                            nxt.clicks = cur.clicks + CLICK_W'(1);
                        end
                    end
                end
            end
            MODE_MULTI: begin
                if (pressed) begin
                    nxt.mode = MODE_DOWN;
                end else if (t_cmp > CMP_W'(r_gap_ticks)) begin
                    nxt.evt  = click_event(cur.clicks);
                    raised   = 1'b1;
                    nxt.mode = MODE_IDLE;
                end
            end
            default: begin
                if (pressed) begin
                    nxt.ticks  = '0;
                    nxt.clicks = '0;
                    nxt.evt    = EV_DOWN;
                    raised     = 1'b1;
                    nxt.mode   = MODE_DOWN;
                end else begin
                    nxt.mode = MODE_IDLE;
                    nxt.evt  = EV_NONE;
                end
            end
        endcase

        now_active = (nxt.mode == MODE_DOWN) || (nxt.mode == MODE_MULTI);
        is_last    = (r_idx == '0);
    end

    // Sequencer: next state, memory strobes
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_active = r_active;
        rd_en    = 1'b0;
        rd_addr  = r_idx;
        wr_en    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && eff_count != '0) begin
                    n_idx    = IDX_W'(eff_count - CNT_W'(1));
                    n_active = '0;
                    rd_en    = 1'b1;
                    rd_addr  = n_idx;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    wr_en    = 1'b1;
                    n_active = r_active + CNT_W'(now_active);
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx - IDX_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = n_idx;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_active <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_active <= n_active;
        end
    end

    // Latch the raw levels of the accepted tick
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_raw <= s_axis_tdata;
        end
    end

    // State memory: write back the updated entry, register read data
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= nxt;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Entry valid bits: an unwritten entry reads as the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld   <= '0;
            r_rdata_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_mem_vld[r_idx] <= 1'b1;
            end
            if (rd_en) begin
                r_rdata_vld <= r_mem_vld[rd_addr];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wr_en) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_out_index  <= BIDX_W'(r_idx);
            r_out_event  <= nxt.evt;
            r_out_new    <= raised;
            r_out_active <= is_last ? (r_active + CNT_W'(now_active)) : '0;
            r_out_last   <= is_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W-EVT_W-1-CNT_W)'(0), r_out_active, r_out_new,
                            r_out_event};
    assign m_axis_tuser  = {(OUT_USER_W-BIDX_W)'(0), r_out_index};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== tb/sv/tb_button_click_and_hold_detector_unit.sv =====
`timescale 1ns / 1ps

module tb_button_click_and_hold_detector_unit;
    import bchd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PRINT_LIMIT  = 30;

    // Register indexes past the end of the register map
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Pressed buttons per directed tick, tick 0 in the lowest byte
    localparam logic [21:0][7:0] DIRECTED_PRESSED = {
        {11{8'h00}}, 8'h20, 8'h60, 8'h70, 8'h70, 8'h78, 8'h78,
        8'h7C, 8'hF8, 8'hFE, 8'hB8, 8'hFF
    };

    typedef struct {
        logic [BIDX_W-1:0] button;
        t_event            code;
        logic              fresh;
        logic [CNT_W-1:0]  active;
        logic              is_last;
    } t_button_report;

    // Per-button event predictor and the queue of reports it expects
    class t_button_event_board;
        logic [RAW_W-1:0]      level_mask;
        logic [CNT_W-1:0]      in_use;
        logic [THR_W-1:0]      short_thr;
        logic [THR_W-1:0]      long_thr;
        logic [THR_W-1:0]      hold_thr;
        logic [THR_W-1:0]      gap_thr;
        t_mode                 mode   [NUM_BUTTONS];
        logic [TICK_WIDTH-1:0] ticks  [NUM_BUTTONS];
        logic [CLICK_W-1:0]    clicks [NUM_BUTTONS];
        t_event                evt    [NUM_BUTTONS];
        t_button_report        pending_reports [$];
        int                    mismatch_count;

        function new();
            level_mask = RST_PRESSED_MASK;
            in_use     = RST_IN_USE;
            short_thr  = RST_SHORT_TICKS;
            long_thr   = RST_LONG_TICKS;
            hold_thr   = RST_HOLD_TICKS;
            gap_thr    = RST_GAP_TICKS;
            mismatch_count = 0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                mode[b]   = MODE_IDLE;
                ticks[b]  = '0;
                clicks[b] = '0;
                evt[b]    = EV_NONE;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_PRESSED_MASK: level_mask = val[RAW_W-1:0];
                CFG_IN_USE:       in_use     = val[CNT_W-1:0];
                CFG_SHORT_TICKS:  short_thr  = val;
                CFG_LONG_TICKS:   long_thr   = val;
                CFG_HOLD_TICKS:   hold_thr   = val;
                CFG_GAP_TICKS:    gap_thr    = val;
                default: ;
            endcase
        endfunction

        function t_event clicks_to_event(logic [CLICK_W-1:0] n);
            if (n <= 8'd1) return EV_CLICK;
            if (n == 8'd2) return EV_DOUBLE;
            return EV_REPEAT;
        endfunction

        // Raise a level event only on its first tick
        function bit enter_event(int b, t_event e);
            if (evt[b] == e) return 1'b0;
            evt[b] = e;
            return 1'b1;
        endfunction

        // Close a press with its release event
        function bit finish_press(int b, t_event e);
            evt[b]  = e;
            mode[b] = MODE_IDLE;
            return 1'b1;
        endfunction

        function bit advance_button(int b, bit pressed);
            logic [TICK_WIDTH:0]   bumped;
            logic [TICK_WIDTH-1:0] t;
            t_mode                 m;
            bit                    raised;
            raised = 1'b0;
            m = mode[b];
            // Count held ticks, reloading from the hold threshold at the top
            if (m == MODE_DOWN || m == MODE_MULTI) begin
                bumped = {1'b0, ticks[b]} + 1'b1;
                if (bumped >= {1'b0, {TICK_WIDTH{1'b1}}})
                    ticks[b] = hold_thr;
                else
                    ticks[b] = bumped[TICK_WIDTH-1:0];
            end
            t = ticks[b];
            case (m)
                MODE_DOWN: begin
                    if (pressed) begin
                        if (clicks[b] != '0) begin
                            if (t > gap_thr) begin
                                evt[b]    = clicks_to_event(clicks[b]);
                                raised    = 1'b1;
                                ticks[b]  = '0;
                                clicks[b] = '0;
                            end
                        end else if (t >= hold_thr) begin
                            raised = enter_event(b, EV_HOLD);
                        end else if (t >= long_thr) begin
                            raised = enter_event(b, EV_LONG_START);
                        end else if (t >= short_thr) begin
                            raised = enter_event(b, EV_SHORT_START);
                        end
                    end else if (t >= hold_thr) begin
                        raised = finish_press(b, EV_HOLD_UP);
                    end else if (t >= long_thr) begin
                        raised = finish_press(b, EV_LONG_UP);
                    end else if (t >= short_thr) begin
                        raised = finish_press(b, EV_SHORT_UP);
                    end else begin
                        mode[b] = MODE_MULTI;
                        if (clicks[b] != CLICK_MAX) clicks[b] = clicks[b] + 1'b1;
                    end
                end
                MODE_MULTI: begin
                    if (pressed) begin
                        mode[b] = MODE_DOWN;
                    end else if (t > gap_thr) begin
                        evt[b]  = clicks_to_event(clicks[b]);
                        raised  = 1'b1;
                        mode[b] = MODE_IDLE;
                    end
                end
                default: begin
                    if (pressed) begin
                        ticks[b]  = '0;
                        clicks[b] = '0;
                        evt[b]    = EV_DOWN;
                        raised    = 1'b1;
                        mode[b]   = MODE_DOWN;
                    end else begin
                        mode[b] = MODE_IDLE;
                        evt[b]  = EV_NONE;
                    end
                end
            endcase
            return raised;
        endfunction

        // Advance every scanned button and queue its report, highest index first
        function void note_tick(logic [RAW_W-1:0] raw);
            int             count;
            int             active;
            bit             raised;
            t_button_report r;
            count  = (in_use > SCAN_LIMIT) ? SCAN_LIMIT : int'(in_use);
            active = 0;
            for (int i = count - 1; i >= 0; i--) begin
                raised = advance_button(i, raw[i] == level_mask[i]);
                if (mode[i] == MODE_DOWN || mode[i] == MODE_MULTI) active++;
                r.button  = BIDX_W'(i);
                r.code    = evt[i];
                r.fresh   = raised;
                r.active  = (i == 0) ? CNT_W'(active) : '0;
                r.is_last = (i == 0);
                pending_reports.push_back(r);
            end
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        task report_mismatch(string what);
            if (mismatch_count < PRINT_LIMIT) $display("%0t ns MISMATCH %s", $time, what);
            mismatch_count++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
                          logic flag);
            t_button_report want;
            if (pending_reports.size() == 0) begin
                report_mismatch($sformatf("result for button %0d with none expected",
                                          user[BIDX_W-1:0]));
                return;
            end
            want = pending_reports.pop_front();
            compare_field("button_index", int'(user[BIDX_W-1:0]), int'(want.button));
            compare_field("event_code", int'(data[3:0]), int'(want.code));
            compare_field("event_new", int'(data[4]), int'(want.fresh));
            compare_field("active_count", int'(data[8:5]), int'(want.active));
            compare_field("last", int'(flag), int'(want.is_last));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [RAW_W-1:0]      s_axis_tdata = '0;   // [7:0] raw_levels
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [3:0] event_code, [4] event_new,
                                                // [8:5] active_count
    logic [OUT_USER_W-1:0] m_axis_tuser;        // [2:0] button_index
    logic                  m_axis_tlast;

    t_button_event_board board = new();
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  cycle_count = 0;
    logic [RAW_W-1:0]    cur_mask = '0;
    logic [RAW_W-1:0]    held_buttons = '0;

    button_click_and_hold_detector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Stall the result stream at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Raw levels that give the wanted pressed buttons under the current mask
    function automatic logic [RAW_W-1:0] levels_for(logic [RAW_W-1:0] pressed);
        return cur_mask ^ ~pressed;
    endfunction

    // Send one scan tick; entered and left just after a falling edge
    task automatic send_tick(input logic [RAW_W-1:0] raw);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_tick(raw);
        @(negedge i_clk);
    endtask

    // Write one register; the caller drops valid after its last write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, val);
        if (idx == CFG_PRESSED_MASK) cur_mask = val[RAW_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [RAW_W-1:0] mask, input logic [CNT_W-1:0] count,
                                  input logic [THR_W-1:0] short_t, input logic [THR_W-1:0] long_t,
                                  input logic [THR_W-1:0] hold_t, input logic [THR_W-1:0] gap_t);
        write_register(CFG_PRESSED_MASK, CFG_DAT_W'(mask));
        write_register(CFG_IN_USE, CFG_DAT_W'(count));
        write_register(CFG_SHORT_TICKS, short_t);
        write_register(CFG_LONG_TICKS, long_t);
        write_register(CFG_HOLD_TICKS, hold_t);
        write_register(CFG_GAP_TICKS, gap_t);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every expected result is in, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Buttons toggle at random with some pure noise ticks mixed in
    task automatic run_random(input int items, input int toggle_pct, input bit pause_midway);
        logic [RAW_W-1:0] raw;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 7) == 0) begin
                raw = RAW_W'($urandom_range(0, 255));
            end else begin
                for (int b = 0; b < RAW_W; b++)
                    if ($urandom_range(0, 99) < toggle_pct) held_buttons[b] = ~held_buttons[b];
                raw = levels_for(held_buttons);
            end
            send_tick(raw);
            if (pause_midway && n == items / 2) wait_idle();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single, double and triple clicks, short, long and hold presses,
        // and a pending click flushed by a second press that is held past the gap
        tx_idle_pct = 31;
        rx_idle_pct = 75;
        apply_settings(8'h00, 4'd8, 16'd6, 16'd8, 16'd10, 16'd7);
        for (int n = 0; n < 22; n++) send_tick(levels_for(DIRECTED_PRESSED[n]));
        wait_idle();

        // Ignore writes past the register map; scan nothing with zero buttons in use
        write_register(CFG_SPARE_LO, '1);
        write_register(CFG_SPARE_HI, '1);
        write_register(CFG_IN_USE, '0);
        i_cfg_valid <= 1'b0;
        for (int n = 0; n < 3; n++) send_tick(RAW_W'($urandom_range(0, 255)));
        wait_idle();

        // Random, sender sparse and receiver sparser
        apply_settings(8'h00, 4'd8, 16'd2, 16'd5, 16'd9, 16'd3);
        run_random(30, 30, 1'b0);
        wait_idle();
        apply_settings(8'hFF, 4'd3, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(30, 40, 1'b0);
        wait_idle();

        // Random, idling swapped; more buttons than the block scans
        tx_idle_pct = 75;
        rx_idle_pct = 31;
        apply_settings(RAW_W'($urandom_range(0, 255)), 4'd15, 16'd6, 16'd3, 16'd4, 16'd8);
        run_random(30, 25, 1'b0);
        wait_idle();
        apply_settings(RAW_W'($urandom_range(0, 255)), 4'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF);
        run_random(30, 35, 1'b0);
        wait_idle();

        // Random, no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_settings(RAW_W'($urandom_range(0, 255)), 4'd8, 16'd3, 16'd7, 16'd12, 16'd5);
        run_random(30, 20, 1'b1);
        wait_idle();
        apply_settings(8'h5A, 4'd1, 16'd1, 16'd2, 16'd3, 16'd1);
        run_random(30, 30, 1'b0);
        wait_idle();

        if (board.mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
